// ----- rtl/vhcj_pkg.sv -----
// Shared types, constants and helpers for the voxel hash colour jitter block.
package vhcj_pkg;

    localparam int POS_W        = 10;
    localparam int Q16_W        = 17;
    localparam int BYTE_W       = 8;
    localparam int WORD_W       = 32;
    localparam int CFG_IDX_W    = 3;
    localparam int N_LANE       = 4;
    localparam int CLIP_DIM_DEF = 1024;

    localparam logic [Q16_W-1:0] FULL_Q16 = 17'h10000;

    // coordinate mixers and the two finalizer multipliers
    localparam logic [WORD_W-1:0] HASH_MX = 32'h8da6b343;
    localparam logic [WORD_W-1:0] HASH_MY = 32'hd8163841;
    localparam logic [WORD_W-1:0] HASH_MZ = 32'hcb1ab31f;
    localparam logic [WORD_W-1:0] HASH_M1 = 32'h7feb352d;
    localparam logic [WORD_W-1:0] HASH_M2 = 32'h846ca68b;

    // per channel seed offset: red, green, blue, roughness
    localparam logic [WORD_W-1:0] SEED_OFS [N_LANE] = '{32'd0, 32'd71, 32'd149, 32'd227};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HASH_SEED = 3'd0,
        CFG_COLOUR_AMT = 3'd1,
        CFG_ROUGH_AMT = 3'd2,
        CFG_ORIGIN_X = 3'd3,
        CFG_ORIGIN_Y = 3'd4,
        CFG_ORIGIN_Z = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [POS_W-1:0]  pos_z;
        logic [Q16_W-1:0]  strength;
        logic [BYTE_W-1:0] base_red;
        logic [BYTE_W-1:0] base_green;
        logic [BYTE_W-1:0] base_blue;
        logic [BYTE_W-1:0] base_rough;
    } t_in_word;

    typedef struct packed {
        logic [BYTE_W-1:0] out_red;
        logic [BYTE_W-1:0] out_green;
        logic [BYTE_W-1:0] out_blue;
        logic [BYTE_W-1:0] out_rough;
        logic              kept_base;
    } t_out_word;

    // front end to lanes
    typedef struct packed {
        logic                          valid;
        logic [WORD_W-1:0]             mix;
        logic [Q16_W-1:0]              col_amt;
        logic [Q16_W-1:0]              rough_amt;
        logic [N_LANE-1:0][BYTE_W-1:0] base;
        logic                          kept;
    } t_front;

    // lane to merge stage
    typedef struct packed {
        logic              valid;
        logic              kept;
        logic [BYTE_W-1:0] value;
    } t_lane_out;

    function automatic logic [Q16_W-1:0] sat_q16(input logic [Q16_W-1:0] v);
        sat_q16 = (v > FULL_Q16) ? FULL_Q16 : v;
    endfunction

endpackage

// ----- rtl/vhcj_front.sv -----
// Shared front end: clip wrap, world coordinates, coordinate mix and channel amounts.
module vhcj_front
    import vhcj_pkg::*;
#(
    parameter int CLIP_DIM = CLIP_DIM_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_in_word          i_word,
    input  logic [WORD_W-1:0] i_origin_x,
    input  logic [WORD_W-1:0] i_origin_y,
    input  logic [WORD_W-1:0] i_origin_z,
    input  logic [Q16_W-1:0]  i_colour_amt,
    input  logic [Q16_W-1:0]  i_rough_amt,
    output t_front            o_front
);

    localparam int RCP_SH = 20;
    localparam int PRD_W  = POS_W + RCP_SH;
    localparam logic [RCP_SH-1:0] RCP   = RCP_SH'((1 << RCP_SH) / CLIP_DIM);
    localparam logic [WORD_W-1:0] DIM32 = WORD_W'(CLIP_DIM);

    // stage 1: captured word
    logic [3:0]                    r_v;
    logic [2:0][POS_W-1:0]         r1_pos;
    logic [Q16_W-1:0]              r1_st;
    logic [N_LANE-1:0][BYTE_W-1:0] r1_base;
    logic                          r1_kept;
    // stage 2: quotient estimate, amounts
    logic [2:0][POS_W-1:0]         r2_pos;
    logic [2:0][POS_W-1:0]         r2_q;
    logic [Q16_W-1:0]              r2_ca;
    logic [Q16_W-1:0]              r2_ra;
    logic [N_LANE-1:0][BYTE_W-1:0] r2_base;
    logic                          r2_kept;
    // stage 3: world coordinates
    logic [2:0][WORD_W-1:0]        r3_w;
    logic [Q16_W-1:0]              r3_ca;
    logic [Q16_W-1:0]              r3_ra;
    logic [N_LANE-1:0][BYTE_W-1:0] r3_base;
    logic                          r3_kept;
    // stage 4: mixed coordinates
    logic [WORD_W-1:0]             r4_mix;
    logic [Q16_W-1:0]              r4_ca;
    logic [Q16_W-1:0]              r4_ra;
    logic [N_LANE-1:0][BYTE_W-1:0] r4_base;
    logic                          r4_kept;

    logic [2:0][POS_W-1:0]         n_q;
    logic [2:0][WORD_W-1:0]        n_w;
    logic [Q16_W-1:0]              n_ca;
    logic [Q16_W-1:0]              n_ra;
    logic [WORD_W-1:0]             n_mix;
    logic [2:0][WORD_W-1:0]        origin;

    assign origin = {i_origin_z, i_origin_y, i_origin_x};

    always_comb begin
        logic [PRD_W-1:0]  prd;
        logic [WORD_W-1:0] qd;
        logic [POS_W-1:0]  rem;
        for (int a = 0; a < 3; a++) begin
            // reciprocal estimate, low by at most one
            prd    = PRD_W'(r1_pos[a]) * PRD_W'(RCP);
            n_q[a] = prd[PRD_W-1:RCP_SH];
            qd     = WORD_W'(r2_q[a]) * DIM32;
            rem    = r2_pos[a] - qd[POS_W-1:0];
            if (WORD_W'(rem) >= DIM32) begin
                rem = rem - DIM32[POS_W-1:0];
            end
            n_w[a] = origin[a] + WORD_W'(rem);
        end
    end

    assign n_ca = Q16_W'((34'(sat_q16(i_colour_amt)) * 34'(r1_st)) >> 16);
    assign n_ra = Q16_W'((34'(sat_q16(i_rough_amt)) * 34'(r1_st)) >> 16);
    assign n_mix = (r3_w[0] * HASH_MX) ^ (r3_w[1] * HASH_MY) ^ (r3_w[2] * HASH_MZ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pos  <= {i_word.pos_z, i_word.pos_y, i_word.pos_x};
            r1_st   <= sat_q16(i_word.strength);
            r1_base <= {i_word.base_rough, i_word.base_blue, i_word.base_green,
                        i_word.base_red};
            r1_kept <= (i_word.strength == '0);

            r2_pos  <= r1_pos;
            r2_q    <= n_q;
            r2_ca   <= n_ca;
            r2_ra   <= n_ra;
            r2_base <= r1_base;
            r2_kept <= r1_kept;

            r3_w    <= n_w;
            r3_ca   <= r2_ca;
            r3_ra   <= r2_ra;
            r3_base <= r2_base;
            r3_kept <= r2_kept;

            r4_mix  <= n_mix;
            r4_ca   <= r3_ca;
            r4_ra   <= r3_ra;
            r4_base <= r3_base;
            r4_kept <= r3_kept;
        end
    end

    assign o_front.valid     = r_v[3];
    assign o_front.mix       = r4_mix;
    assign o_front.col_amt   = r4_ca;
    assign o_front.rough_amt = r4_ra;
    assign o_front.base      = r4_base;
    assign o_front.kept      = r4_kept;

    a_valid_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && r_v[0] |=> r_v[1])
        else $error("front valid lost between stage 1 and 2");

endmodule

// ----- rtl/vhcj_lane.sv -----
// One channel lane: hash finalizer, signed unit scaling, floor and clamp.
module vhcj_lane
    import vhcj_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [WORD_W-1:0] i_mix,
    input  logic [WORD_W-1:0] i_seed,
    input  logic [Q16_W-1:0]  i_amt,
    input  logic [BYTE_W-1:0] i_base,
    input  logic              i_kept,
    output t_lane_out         o_lane
);

    localparam int PROD_W = WORD_W + Q16_W;   // signed unit times amount
    localparam int TOT_W  = 58;               // room for base<<47 plus delta
    localparam int FRAC   = 47;

    logic [4:0]                r_v;
    logic [WORD_W-1:0]         r_m1;
    logic [WORD_W-1:0]         r_m2;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [TOT_W-1:0]   r_dlt;
    logic [BYTE_W-1:0]         r_byte;
    logic [Q16_W-1:0]          r_amt1;
    logic [Q16_W-1:0]          r_amt2;
    logic [3:0][BYTE_W-1:0]    r_base;
    logic [4:0]                r_kept;

    logic [WORD_W-1:0]         n_m1;
    logic [WORD_W-1:0]         n_m2;
    logic signed [PROD_W-1:0]  n_prod;
    logic signed [TOT_W-1:0]   n_dlt;
    logic [BYTE_W-1:0]         n_byte;

    always_comb begin
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] h;
        logic signed [WORD_W-1:0] u;
        x      = i_mix ^ i_seed;
        x      = x ^ (x >> 16);
        n_m1   = x * HASH_M1;
        y      = r_m1 ^ (r_m1 >> 15);
        n_m2   = y * HASH_M2;
        h      = r_m2 ^ (r_m2 >> 16);
        // h - 2^31 as Q1.31
        u      = signed'({~h[WORD_W-1], h[WORD_W-2:0]});
        n_prod = PROD_W'(u) * PROD_W'(signed'({1'b0, r_amt2}));
        // times 255
        n_dlt  = (TOT_W'(r_prod) <<< 8) - TOT_W'(r_prod);
    end

    always_comb begin
        logic signed [TOT_W-1:0] tot;
        logic [TOT_W-FRAC-1:0]   q;
        tot = signed'({3'b000, r_base[3], FRAC'(0)}) + r_dlt;
        q   = tot[TOT_W-1:FRAC];
        if (tot[TOT_W-1]) begin
            n_byte = '0;
        end else if (q > (TOT_W-FRAC)'(255)) begin
            n_byte = 8'hff;
        end else begin
            n_byte = q[BYTE_W-1:0];
        end
        if (r_kept[3]) begin
            n_byte = r_base[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1   <= n_m1;
            r_m2   <= n_m2;
            r_prod <= n_prod;
            r_dlt  <= n_dlt;
            r_byte <= n_byte;
            r_amt1 <= i_amt;
            r_amt2 <= r_amt1;
            r_base <= {r_base[2:0], i_base};
            r_kept <= {r_kept[3:0], i_kept};
        end
    end

    assign o_lane.valid = r_v[4];
    assign o_lane.kept  = r_kept[4];
    assign o_lane.value = r_byte;

    a_zero_amt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && r_v[1] && (r_amt2 == '0) |=> (r_prod == '0))
        else $error("zero amount gave a nonzero jitter product");

endmodule

// ----- rtl/vhcj_merge.sv -----
// Merge stage: gathers the lane bytes into the output word register, drives the pipe enable.
module vhcj_merge
    import vhcj_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_lane_out [N_LANE-1:0]      i_lane,
    input  logic                        i_stall,
    output logic                        o_en,
    output logic                        o_valid,
    output t_out_word                   o_word
);

    logic      r_valid;
    t_out_word r_word;
    t_out_word n_word;

    // whole pipe advances unless a finished word is held
    assign o_en = !r_valid || !i_stall;

    always_comb begin
        n_word.out_red   = i_lane[0].value;
        n_word.out_green = i_lane[1].value;
        n_word.out_blue  = i_lane[2].value;
        n_word.out_rough = i_lane[3].value;
        n_word.kept_base = i_lane[0].kept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_lane[0].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_lane[0].valid == i_lane[N_LANE-1].valid) && (i_lane[0].kept == i_lane[1].kept
         || !i_lane[0].valid))
        else $error("lanes out of step");

    a_word_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_en && i_lane[0].valid |=> o_valid)
        else $error("lane word not registered at output");

endmodule

// ----- rtl/voxel_hash_colour_jitter.sv -----
// Voxel hash colour jitter top level: config registers, front end, four lanes, merge.
// A word passes the front stages, lane stages and output register to o_out_valid.
// Throughput: one word per cycle; the pipe is one shared enable, so it holds
// (and o_in_stall rises) only while a finished word waits on i_out_stall.
// Reset (synchronous, i_rst_n low) clears all config registers to zero and
// empties the pipe; the config port is always ready.
module voxel_hash_colour_jitter
    import vhcj_pkg::*;
#(
    parameter int CLIP_DIM = CLIP_DIM_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_word             i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_word            o_out_word,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    logic [WORD_W-1:0] r_seed;
    logic [Q16_W-1:0]  r_col_amt;
    logic [Q16_W-1:0]  r_rough_amt;
    logic [WORD_W-1:0] r_org_x;
    logic [WORD_W-1:0] r_org_y;
    logic [WORD_W-1:0] r_org_z;

    logic                   en;
    t_front                 front;
    t_lane_out [N_LANE-1:0] lane;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= '0;
            r_col_amt   <= '0;
            r_rough_amt <= '0;
            r_org_x     <= '0;
            r_org_y     <= '0;
            r_org_z     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_HASH_SEED:  r_seed      <= i_cfg_data;
                CFG_COLOUR_AMT: r_col_amt   <= i_cfg_data[Q16_W-1:0];
                CFG_ROUGH_AMT:  r_rough_amt <= i_cfg_data[Q16_W-1:0];
                CFG_ORIGIN_X:   r_org_x     <= i_cfg_data;
                CFG_ORIGIN_Y:   r_org_y     <= i_cfg_data;
                CFG_ORIGIN_Z:   r_org_z     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    vhcj_front #(
        .CLIP_DIM(CLIP_DIM)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_in_valid),
        .i_word      (i_in_word),
        .i_origin_x  (r_org_x),
        .i_origin_y  (r_org_y),
        .i_origin_z  (r_org_z),
        .i_colour_amt(r_col_amt),
        .i_rough_amt (r_rough_amt),
        .o_front     (front)
    );

    for (genvar g = 0; g < N_LANE; g++) begin : g_lane
        vhcj_lane u_lane (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_valid(front.valid),
            .i_mix  (front.mix),
            .i_seed (r_seed + SEED_OFS[g]),
            .i_amt  ((g == N_LANE - 1) ? front.rough_amt : front.col_amt),
            .i_base (front.base[g]),
            .i_kept (front.kept),
            .o_lane (lane[g])
        );
    end

    vhcj_merge u_merge (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_lane (lane),
        .i_stall(i_out_stall),
        .o_en   (en),
        .o_valid(o_out_valid),
        .o_word (o_out_word)
    );

    a_kept_from_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && front.valid && front.kept |-> (front.col_amt == '0) && (front.rough_amt == '0))
        else $error("zero strength word carries a nonzero amount");

endmodule

// ----- dv/jitter_checker.sv -----
// Checker for voxel_hash_colour_jitter: predicts each jittered word and compares it on output.
module jitter_checker
    import vhcj_pkg::*;
#(
    parameter int CLIP_DIM = CLIP_DIM_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_word             i_in_word,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_word            i_out_word,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data,
    output int                   o_errors,
    output int                   o_pending
);

    localparam logic [31:0] MIX_X     = 32'h8da6b343;
    localparam logic [31:0] MIX_Y     = 32'hd8163841;
    localparam logic [31:0] MIX_Z     = 32'hcb1ab31f;
    localparam logic [31:0] FIN_A     = 32'h7feb352d;
    localparam logic [31:0] FIN_B     = 32'h846ca68b;
    localparam logic [31:0] OFS_GREEN = 32'd71;
    localparam logic [31:0] OFS_BLUE  = 32'd149;
    localparam logic [31:0] OFS_ROUGH = 32'd227;
    localparam logic [16:0] Q16_ONE   = 17'h10000;
    localparam int          FRAC      = 47;

    // shadow copy of the config registers
    logic [31:0] seed_r;
    logic [16:0] colour_amt_r;
    logic [16:0] rough_amt_r;
    logic [31:0] org_x_r;
    logic [31:0] org_y_r;
    logic [31:0] org_z_r;

    t_out_word expected_colours[$];

    function automatic logic [16:0] clamp_full(logic [16:0] v);
        return (v > Q16_ONE) ? Q16_ONE : v;
    endfunction

    function automatic logic [31:0] hash_lane(logic [31:0] wx, logic [31:0] wy,
                                              logic [31:0] wz, logic [31:0] seed);
        logic [31:0] h;
        h = (wx * MIX_X) ^ (wy * MIX_Y) ^ (wz * MIX_Z) ^ seed;
        h = h ^ (h >> 16);
        h = h * FIN_A;
        h = h ^ (h >> 15);
        h = h * FIN_B;
        h = h ^ (h >> 16);
        return h;
    endfunction

    // base + (h - 2^31) * amt * 255 / 2^47, floored and clamped
    function automatic logic [7:0] jitter_byte(logic [7:0] base, logic [31:0] amt,
                                               logic [31:0] h);
        longint unit;
        longint delta;
        longint total;
        longint q;
        unit  = longint'({32'd0, h}) - 64'sd2147483648;
        delta = unit * longint'({32'd0, amt}) * 64'sd255;
        total = (longint'({56'd0, base}) <<< FRAC) + delta;
        if (total < 0)
            return 8'd0;
        q = total >>> FRAC;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function automatic t_out_word predict_jitter(t_in_word w);
        t_out_word   r;
        logic [16:0] st;
        logic [31:0] wx, wy, wz, ca, ra;
        st = clamp_full(w.strength);
        r.out_red   = w.base_red;
        r.out_green = w.base_green;
        r.out_blue  = w.base_blue;
        r.out_rough = w.base_rough;
        r.kept_base = 1'b1;
        if (st == '0)
            return r;
        wx = org_x_r + 32'(w.pos_x % CLIP_DIM);
        wy = org_y_r + 32'(w.pos_y % CLIP_DIM);
        wz = org_z_r + 32'(w.pos_z % CLIP_DIM);
        ca = 32'((longint'(clamp_full(colour_amt_r)) * longint'(st)) >>> 16);
        ra = 32'((longint'(clamp_full(rough_amt_r)) * longint'(st)) >>> 16);
        r.out_red   = jitter_byte(w.base_red, ca, hash_lane(wx, wy, wz, seed_r));
        r.out_green = jitter_byte(w.base_green, ca, hash_lane(wx, wy, wz, seed_r + OFS_GREEN));
        r.out_blue  = jitter_byte(w.base_blue, ca, hash_lane(wx, wy, wz, seed_r + OFS_BLUE));
        r.out_rough = jitter_byte(w.base_rough, ra, hash_lane(wx, wy, wz, seed_r + OFS_ROUGH));
        r.kept_base = 1'b0;
        return r;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            o_errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            seed_r       = '0;
            colour_amt_r = '0;
            rough_amt_r  = '0;
            org_x_r      = '0;
            org_y_r      = '0;
            org_z_r      = '0;
            expected_colours.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HASH_SEED:  seed_r = i_cfg_data;
                    CFG_COLOUR_AMT: colour_amt_r = i_cfg_data[16:0];
                    CFG_ROUGH_AMT:  rough_amt_r = i_cfg_data[16:0];
                    CFG_ORIGIN_X:   org_x_r = i_cfg_data;
                    CFG_ORIGIN_Y:   org_y_r = i_cfg_data;
                    CFG_ORIGIN_Z:   org_z_r = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                expected_colours.push_back(predict_jitter(i_in_word));
            if (i_out_valid && !i_out_stall) begin
                if (expected_colours.size() == 0) begin
                    o_errors++;
                    $display("%0t: output word with nothing expected, expected none actual %h",
                             $time, i_out_word);
                end else begin
                    want = expected_colours.pop_front();
                    check_field("out_red", want.out_red, i_out_word.out_red);
                    check_field("out_green", want.out_green, i_out_word.out_green);
                    check_field("out_blue", want.out_blue, i_out_word.out_blue);
                    check_field("out_rough", want.out_rough, i_out_word.out_rough);
                    check_field("kept_base", {7'd0, want.kept_base},
                                {7'd0, i_out_word.kept_base});
                end
            end
        end
        o_pending = expected_colours.size();
    end

endmodule

// ----- dv/tb_voxel_hash_colour_jitter.sv -----
// Testbench top for voxel_hash_colour_jitter: stimulus, idling, back-pressure and verdict.
module tb_voxel_hash_colour_jitter;
    import vhcj_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 6;
    localparam int STALL_PCT       = 19;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int QUIET_PHASE     = 2;
    localparam int PRESSURE_PHASE  = 4;
    localparam int SPARE_PHASE     = 1;
    localparam int HOLD_CYCLES     = 64;
    localparam int DRAIN_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT  = 2000;

    // indexes past the last register; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
    localparam logic [Q16_W-1:0]     Q16_MAX     = '1;
    localparam logic [31:0]          AMT_FULL    = 32'h0001_0000;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in_word             i_in_word   = '0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [WORD_W-1:0]    i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_word            o_out_word;
    logic                 o_cfg_ready;

    int error_count;
    int pending_words;

    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;
    bit sink_hold_go = 1'b0;

    always #HALF_PERIOD i_clk = ~i_clk;

    voxel_hash_colour_jitter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    jitter_checker u_jitter_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (error_count),
        .o_pending   (pending_words)
    );

    function automatic t_in_word voxel(int px, int py, int pz, int st,
                                       int r, int g, int b, int ro);
        t_in_word w;
        w.pos_x      = POS_W'(px);
        w.pos_y      = POS_W'(py);
        w.pos_z      = POS_W'(pz);
        w.strength   = Q16_W'(st);
        w.base_red   = BYTE_W'(r);
        w.base_green = BYTE_W'(g);
        w.base_blue  = BYTE_W'(b);
        w.base_rough = BYTE_W'(ro);
        return w;
    endfunction

    function automatic logic [Q16_W-1:0] rand_strength();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return FULL_Q16;
            2:       return Q16_W'($urandom_range(65537, 131071));
            3:       return Q16_W'($urandom_range(1, 16));
            default: return Q16_W'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 4))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_in_word rand_voxel();
        t_in_word w;
        w.pos_x      = POS_W'($urandom);
        w.pos_y      = POS_W'($urandom);
        w.pos_z      = POS_W'($urandom);
        w.strength   = rand_strength();
        w.base_red   = rand_byte();
        w.base_green = rand_byte();
        w.base_blue  = rand_byte();
        w.base_rough = rand_byte();
        return w;
    endfunction

    // upper data bits beyond the 17-bit register are sent too
    function automatic logic [31:0] rand_amount();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return AMT_FULL;
            2:       return $urandom_range(65537, 131071);
            3:       return $urandom;
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    function automatic logic [31:0] rand_origin();
        case ($urandom_range(0, 4))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'hffff_ffff - $urandom_range(0, 1023);
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_drained();
        do @(posedge i_clk); while (pending_words != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic program_regs(logic [31:0] seed, logic [31:0] col_amt,
                                logic [31:0] rough_amt, logic [31:0] ox,
                                logic [31:0] oy, logic [31:0] oz, bit with_spares);
        wait_drained();
        write_reg(CFG_HASH_SEED, seed);
        write_reg(CFG_COLOUR_AMT, col_amt);
        write_reg(CFG_ROUGH_AMT, rough_amt);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_ORIGIN_Z, oz);
        if (with_spares) begin
            write_reg(CFG_SPARE_A, $urandom);
            write_reg(CFG_SPARE_B, $urandom);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // word stays put until the edge that takes it
    task automatic send_voxel(t_in_word w);
        while (src_idle_on && $urandom_range(0, 99) < STALL_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic end_batch();
        i_in_valid <= 1'b0;
        wait_drained();
    endtask

    initial begin : sink
        forever begin
            @(posedge i_clk);
            if (sink_hold_go) begin
                sink_hold_go = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_stall <= sink_idle_on && ($urandom_range(0, 99) < STALL_PCT);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // registers at reset: zero amounts leave bytes alone; zero strength sets kept_base
        send_voxel(voxel(0, 0, 0, FULL_Q16, 0, 255, 128, 77));
        send_voxel(voxel(1023, 1023, 1023, 0, 12, 34, 56, 78));
        send_voxel(voxel(5, 6, 7, Q16_MAX, 255, 0, 255, 0));
        end_batch();

        // full swing on every channel
        program_regs(32'd0, AMT_FULL, AMT_FULL, 32'd0, 32'd0, 32'd0, 1'b0);
        send_voxel(voxel(0, 0, 0, FULL_Q16, 0, 0, 0, 0));
        send_voxel(voxel(0, 0, 0, FULL_Q16, 255, 255, 255, 255));
        send_voxel(voxel(1023, 1023, 1023, FULL_Q16, 128, 128, 128, 128));
        send_voxel(voxel(1023, 0, 512, 1, 0, 255, 0, 255));
        send_voxel(voxel(0, 1023, 1, 65535, 255, 0, 255, 0));
        send_voxel(voxel(512, 512, 512, 65537, 100, 150, 200, 250));
        send_voxel(voxel(3, 3, 3, Q16_MAX, 1, 254, 127, 128));
        send_voxel(voxel(7, 8, 9, 0, 255, 255, 255, 255));
        send_voxel(voxel(1, 2, 3, 32768, 0, 128, 255, 64));
        send_voxel(voxel(1023, 1023, 0, FULL_Q16, 0, 255, 0, 255));
        send_voxel(voxel(0, 1023, 0, FULL_Q16, 255, 0, 255, 0));
        end_batch();

        // amounts above full, seed and origins at their extremes, world coords wrap
        program_regs(32'hffff_ffff, 32'h0001_ffff, 32'hffff_ffff, 32'h7fff_ffff,
                     32'h8000_0000, 32'hffff_ffff, 1'b1);
        send_voxel(voxel(1023, 1023, 1023, FULL_Q16, 0, 255, 128, 255));
        send_voxel(voxel(0, 0, 0, Q16_MAX, 255, 0, 0, 255));
        send_voxel(voxel(1, 1, 1, 0, 9, 8, 7, 6));
        send_voxel(voxel(512, 1023, 0, 40000, 200, 50, 100, 150));
        send_voxel(voxel(1023, 0, 1023, 1, 0, 0, 255, 255));
        end_batch();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            program_regs($urandom, rand_amount(), rand_amount(), rand_origin(),
                         rand_origin(), rand_origin(), ph == SPARE_PHASE);
            src_idle_on  = (ph != QUIET_PHASE) && (ph != PRESSURE_PHASE);
            sink_idle_on = (ph != QUIET_PHASE);
            // sink holds off while words keep coming, so the pipe backs up
            if (ph == PRESSURE_PHASE)
                sink_hold_go = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_voxel(rand_voxel());
            end_batch();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
